// ===== hdl/htd_pkg.sv =====
// Shared types and constants for the binary-tree Huffman decoder.
// No dependencies; imported by htd_ctrl, htd_dp and huffman_tree_decoder_core.
`default_nettype none

package htd_pkg;

	// Item opcode on the mode port
	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_DECODE = 1'b1;

	// Result status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_EMPTY    = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_CONFLICT = 2'd3;

	// Controller to datapath commands
	typedef struct packed {
		logic       accept;     // latch item fields, start walk at the root
		logic       walk_adv;   // step the insert walk to the existing child
		logic       link;       // hook the first new node onto the last existing node
		logic       build;      // write one new node of the chain
		logic       dec_done;   // finish a decode bit: result and walk update
		logic       res_load;   // load an insert result
		logic [1:0] res_status; // status for res_load
	} htd_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic in_decode;  // item at the ports is a decode bit
		logic in_len_bad; // item at the ports has an illegal code length
		logic cur_leaf;   // current walk node is a leaf
		logic kid_zero;   // current walk node has no child for this bit
		logic last_bit;   // one code bit left
		logic no_room;    // remaining bits need more nodes than are free
	} htd_sts_t;

endpackage

`default_nettype wire

// ===== hdl/htd_ctrl.sv =====
// Controller state machine for the Huffman tree decoder.
// Depends on htd_pkg; drives htd_dp through htd_cmd_t.
`default_nettype none

module htd_ctrl
	import htd_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output logic          busy,
	output logic          done,
	input  wire htd_sts_t sts,
	output htd_cmd_t      cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DEC,
		S_WALK,
		S_LINK,
		S_BUILD
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   done_q;

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

	// Next state and commands
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					if (sts.in_decode) begin
						state_d = S_DEC;
					end else if (sts.in_len_bad) begin
						cmd.res_load   = 1'b1;
						cmd.res_status = ST_CONFLICT;
					end else begin
						state_d = S_WALK;
					end
				end
			end
			S_DEC: begin
				cmd.dec_done = 1'b1;
				state_d      = S_IDLE;
			end
			S_WALK: begin
				priority if (sts.cur_leaf) begin
					cmd.res_load   = 1'b1;
					cmd.res_status = ST_CONFLICT;
					state_d        = S_IDLE;
				end else if (sts.kid_zero) begin
					if (sts.no_room) begin
						cmd.res_load   = 1'b1;
						cmd.res_status = ST_FULL;
						state_d        = S_IDLE;
					end else begin
						state_d = S_LINK;
					end
				end else if (sts.last_bit) begin
					// path ends on a node that already exists
					cmd.res_load   = 1'b1;
					cmd.res_status = ST_CONFLICT;
					state_d        = S_IDLE;
				end else begin
					cmd.walk_adv = 1'b1;
				end
			end
			S_LINK: begin
				cmd.link = 1'b1;
				state_d  = S_BUILD;
			end
			S_BUILD: begin
				cmd.build = 1'b1;
				if (sts.last_bit) begin
					cmd.res_load   = 1'b1;
					cmd.res_status = ST_OK;
					state_d        = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.res_load | cmd.dec_done;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/htd_dp.sv =====
// Datapath for the Huffman tree decoder: node memory, root and walk
// registers, insert walk and node allocation. Depends on htd_pkg.
`default_nettype none

module htd_dp
	import htd_pkg::*;
#(
	parameter int NODE_COUNT   = 512,
	parameter int MAX_CODE_LEN = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire htd_cmd_t    cmd,
	output htd_sts_t         sts,
	input  wire logic        mode,
	input  wire logic [7:0]  symbol,
	input  wire logic [15:0] code_bits,
	input  wire logic [4:0]  code_len,
	input  wire logic        bit_value,
	output logic             symbol_valid,
	output logic [7:0]       symbol_out,
	output logic [1:0]       status
);

	localparam int IW     = $clog2(NODE_COUNT);
	localparam int NW     = $clog2(NODE_COUNT + 1);
	localparam int CW     = (NW > 5) ? NW : 5;
	localparam int LenLim = (MAX_CODE_LEN < 16) ? MAX_CODE_LEN : 16;
	localparam int DW     = 9 + 2 * IW;

	// Node word: {leaf, symbol, left child, right child}; child 0 means none
	logic [DW-1:0] mem [NODE_COUNT];
	logic [DW-1:0] rd_q;

	// Root node lives in registers; the walk node's children are cached
	logic [IW-1:0] root_l_q, root_r_q;
	logic [IW-1:0] wp_q, wp_l_q, wp_r_q;
	logic [NW-1:0] nu_q;

	// Per-item registers
	logic [IW-1:0] cur_idx_q;
	logic          from_mem_q;
	logic [4:0]    i_q;
	logic [15:0]   code_q;
	logic [7:0]    sym_q;
	logic [IW-1:0] dchild_q;
	logic          dempty_q;

	logic          rd_leaf;
	logic [7:0]    rd_sym;
	logic [IW-1:0] rd_l, rd_r;
	logic [IW-1:0] cur_l, cur_r, kid;
	logic          bsel, bnext;
	logic [NW-1:0] free_cnt, nu_p1;
	logic [IW-1:0] nu_lo, nu_nx;
	logic [IW-1:0] lnk_l, lnk_r;
	logic [IW-1:0] dec_c, rd_addr, waddr;
	logic [DW-1:0] wdata, bld_w;
	logic          we;

	assign rd_leaf = rd_q[DW-1];
	assign rd_sym  = rd_q[DW-2 -: 8];
	assign rd_l    = rd_q[2*IW-1 -: IW];
	assign rd_r    = rd_q[IW-1:0];

	// Current insert walk node: root registers or the last memory read
	assign cur_l = from_mem_q ? rd_l : root_l_q;
	assign cur_r = from_mem_q ? rd_r : root_r_q;
	assign bsel  = code_q[4'(i_q - 5'd1)];
	assign bnext = code_q[4'(i_q - 5'd2)];
	assign kid   = bsel ? cur_r : cur_l;

	// Allocation
	assign free_cnt = NW'(NODE_COUNT) - nu_q;
	assign nu_p1    = nu_q + NW'(1);
	assign nu_lo    = nu_q[IW-1:0];
	assign nu_nx    = nu_p1[IW-1:0];

	// Status to the controller
	assign sts.in_decode  = (mode == MODE_DECODE);
	assign sts.in_len_bad = (code_len == 5'd0) || (code_len > 5'(LenLim));
	assign sts.cur_leaf   = from_mem_q & rd_leaf;
	assign sts.kid_zero   = (kid == '0);
	assign sts.last_bit   = (i_q == 5'd1);
	assign sts.no_room    = CW'(i_q) > CW'(free_cnt);

	// Memory port selection
	assign dec_c   = bit_value ? wp_r_q : wp_l_q;
	assign rd_addr = cmd.walk_adv ? kid : dec_c;
	assign lnk_l   = bsel ? cur_l : nu_lo;
	assign lnk_r   = bsel ? nu_lo : cur_r;
	assign bld_w   = sts.last_bit ? {1'b1, sym_q, {IW{1'b0}}, {IW{1'b0}}}
		: {1'b0, 8'h00, (bnext ? {IW{1'b0}} : nu_nx), (bnext ? nu_nx : {IW{1'b0}})};
	assign we      = (cmd.link & from_mem_q) | cmd.build;
	assign waddr   = cmd.build ? nu_lo : cur_idx_q;
	assign wdata   = cmd.build ? bld_w : {1'b0, 8'h00, lnk_l, lnk_r};

	// Node memory, registered read; read word held until the next accept or walk step
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (cmd.accept || cmd.walk_adv) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Item and walk registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cur_idx_q  <= '0;
			from_mem_q <= 1'b0;
			i_q        <= code_len;
			code_q     <= code_bits;
			sym_q      <= symbol;
			dchild_q   <= dec_c;
			dempty_q   <= (dec_c == '0);
		end else if (cmd.walk_adv) begin
			cur_idx_q  <= kid;
			from_mem_q <= 1'b1;
			i_q        <= i_q - 5'd1;
		end else if (cmd.build) begin
			i_q        <= i_q - 5'd1;
		end
	end

	// Tree state: root children, allocation count, decode position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_l_q <= '0;
			root_r_q <= '0;
			wp_q     <= '0;
			wp_l_q   <= '0;
			wp_r_q   <= '0;
			nu_q     <= NW'(1);
		end else begin
			if (cmd.link) begin
				if (!from_mem_q) begin
					root_l_q <= lnk_l;
					root_r_q <= lnk_r;
				end
				if (cur_idx_q == wp_q) begin
					wp_l_q <= lnk_l;
					wp_r_q <= lnk_r;
				end
			end
			if (cmd.build) begin
				nu_q <= nu_p1;
			end
			if (cmd.dec_done) begin
				if (dempty_q || rd_leaf) begin
					wp_q   <= '0;
					wp_l_q <= root_l_q;
					wp_r_q <= root_r_q;
				end else begin
					wp_q   <= dchild_q;
					wp_l_q <= rd_l;
					wp_r_q <= rd_r;
				end
			end
		end
	end

	// Result registers
	always_ff @(posedge clk) begin
		if (cmd.dec_done) begin
			symbol_valid <= ~dempty_q & rd_leaf;
			symbol_out   <= (~dempty_q & rd_leaf) ? rd_sym : 8'h00;
			status       <= dempty_q ? ST_EMPTY : ST_OK;
		end else if (cmd.res_load) begin
			symbol_valid <= 1'b0;
			symbol_out   <= 8'h00;
			status       <= cmd.res_status;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/huffman_tree_decoder_core.sv =====
// Top level of the binary-tree Huffman decoder: controller plus datapath.
// Depends on htd_pkg, htd_ctrl and htd_dp.
//
// channel   direction  handshake                 payload
// command   in         start, taken when !busy   mode, symbol, code_bits, code_len, bit_value
// result    out        done, one-cycle strobe    symbol_valid, symbol_out, status
//
// A decode bit does one node memory read of the child, then the
// leaf check and walk update; a new bit is taken only once the last is done.
// An insert walks down one existing tree level per step (a memory read
// each), then links the new branch, then does one memory write per new node.
// A bad code length is answered from the idle state without a tree walk.
// Reset clears the root and the walk position and sets the allocation count to one;
// node memory needs no clearing. done is high one cycle per item and cannot stall.
`default_nettype none

module huffman_tree_decoder_core
	import htd_pkg::*;
#(
	parameter int NODE_COUNT   = 512,
	parameter int MAX_CODE_LEN = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        mode,
	input  wire logic [7:0]  symbol,
	input  wire logic [15:0] code_bits,
	input  wire logic [4:0]  code_len,
	input  wire logic        bit_value,
	output logic             done,
	output logic             symbol_valid,
	output logic [7:0]       symbol_out,
	output logic [1:0]       status
);

	htd_cmd_t cmd;
	htd_sts_t sts;

	// Sequencer
	htd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.sts    (sts),
		.cmd    (cmd)
	);

	// Tree memory and walk datapath
	htd_dp #(
		.NODE_COUNT   (NODE_COUNT),
		.MAX_CODE_LEN (MAX_CODE_LEN)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.mode         (mode),
		.symbol       (symbol),
		.code_bits    (code_bits),
		.code_len     (code_len),
		.bit_value    (bit_value),
		.symbol_valid (symbol_valid),
		.symbol_out   (symbol_out),
		.status       (status)
	);

endmodule

`default_nettype wire
